[rtl/core/asa_pkg.sv]
// Shared types, widths and the arctangent table for the arc sweep angle pipeline.
package asa_pkg;

  localparam int CoordW    = 32;
  localparam int DiffW     = 33;
  localparam int MagW      = 32;
  localparam int ProdW     = 64;
  localparam int SumW      = 67;
  localparam int NormBits  = 40;
  localparam int LenW      = 7;
  localparam int ChunkW    = 16;
  localparam int Chunks    = 5;
  localparam int ClenW     = 5;
  localparam int XyW       = 44;
  localparam int ZW        = 34;
  localparam int AtanW     = 32;
  localparam int TableLen  = 24;
  localparam int ClampW    = 31;
  localparam int AngW      = 32;
  localparam int AdjW      = 33;
  localparam int TurnW     = 16;

  localparam logic [ClampW-1:0] QuarterTurn = ClampW'(64'h4000_0000);
  localparam logic [AngW-1:0]   HalfTurn    = AngW'(64'h8000_0000);
  localparam logic [AdjW-1:0]   FullTurn    = AdjW'(64'h1_0000_0000);
  localparam logic [AdjW-1:0]   RoundHalf   = AdjW'(64'h8000);

  typedef struct packed {
    logic degen;
    logic cw;
    logic dot_neg;
    logic cross_nz;
    logic cross_neg;
  } tag_t;

  function automatic logic [AtanW-1:0] atan_turns(input int unsigned idx);
    logic [AtanW-1:0] a;
    case (idx)
      0:       a = 32'd536870912;
      1:       a = 32'd316933406;
      2:       a = 32'd167458907;
      3:       a = 32'd85004756;
      4:       a = 32'd42667331;
      5:       a = 32'd21354465;
      6:       a = 32'd10679838;
      7:       a = 32'd5340245;
      8:       a = 32'd2670163;
      9:       a = 32'd1335087;
      10:      a = 32'd667544;
      11:      a = 32'd333772;
      12:      a = 32'd166886;
      13:      a = 32'd83443;
      14:      a = 32'd41722;
      15:      a = 32'd20861;
      16:      a = 32'd10430;
      17:      a = 32'd5215;
      18:      a = 32'd2608;
      19:      a = 32'd1304;
      20:      a = 32'd652;
      21:      a = 32'd326;
      22:      a = 32'd163;
      23:      a = 32'd81;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

[rtl/core/asa_prod.sv]
// Difference vectors, magnitudes, products, and dot and cross sums (five stages).
module asa_prod (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  input  logic signed [asa_pkg::CoordW-1:0] start_x,
  input  logic signed [asa_pkg::CoordW-1:0] start_y,
  input  logic signed [asa_pkg::CoordW-1:0] end_x,
  input  logic signed [asa_pkg::CoordW-1:0] end_y,
  input  logic signed [asa_pkg::CoordW-1:0] center_x,
  input  logic signed [asa_pkg::CoordW-1:0] center_y,
  input  logic                              clockwise,
  output logic                              out_valid,
  output asa_pkg::tag_t                     out_tag,
  output logic signed [asa_pkg::SumW-1:0]   dot,
  output logic signed [asa_pkg::SumW-1:0]   cross_sum
);
  import asa_pkg::*;

  logic                    v1, v2, v3, v4, v5;
  tag_t                    tag1, tag2, tag3, tag4, tag5;
  logic signed [DiffW-1:0] sx1, sy1, ex1, ey1;
  logic [MagW-1:0]         sxm2, sym2, exm2, eym2;
  logic                    sxn2, syn2, exn2, eyn2;
  logic [ProdW-1:0]        p0, p1, p2, p3;
  logic                    n0, n1, n2, n3;
  logic signed [SumW-1:0]  t0, t1, t2, t3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end

    sx1 <= DiffW'(start_x) - DiffW'(center_x);
    sy1 <= DiffW'(start_y) - DiffW'(center_y);
    ex1 <= DiffW'(end_x) - DiffW'(center_x);
    ey1 <= DiffW'(end_y) - DiffW'(center_y);
    tag1 <= tag_t'{
      degen: ((start_x == center_x) && (start_y == center_y)) ||
             ((end_x == center_x) && (end_y == center_y)),
      cw: clockwise,
      default: 1'b0
    };

    sxm2 <= sx1[DiffW-1] ? MagW'(-sx1) : MagW'(sx1);
    sym2 <= sy1[DiffW-1] ? MagW'(-sy1) : MagW'(sy1);
    exm2 <= ex1[DiffW-1] ? MagW'(-ex1) : MagW'(ex1);
    eym2 <= ey1[DiffW-1] ? MagW'(-ey1) : MagW'(ey1);
    sxn2 <= sx1[DiffW-1];
    syn2 <= sy1[DiffW-1];
    exn2 <= ex1[DiffW-1];
    eyn2 <= ey1[DiffW-1];
    tag2 <= tag1;

    p0 <= sxm2 * exm2;
    p1 <= sym2 * eym2;
    p2 <= sxm2 * eym2;
    p3 <= sym2 * exm2;
    n0 <= sxn2 ^ exn2;
    n1 <= syn2 ^ eyn2;
    n2 <= sxn2 ^ eyn2;
    n3 <= ~(syn2 ^ exn2);
    tag3 <= tag2;

    t0 <= n0 ? -SumW'(p0) : SumW'(p0);
    t1 <= n1 ? -SumW'(p1) : SumW'(p1);
    t2 <= n2 ? -SumW'(p2) : SumW'(p2);
    t3 <= n3 ? -SumW'(p3) : SumW'(p3);
    tag4 <= tag3;

    dot       <= t0 + t1;
    cross_sum <= t2 + t3;
    tag5      <= tag4;
  end

  assign out_valid = v5;
  assign out_tag   = tag5;

endmodule

[rtl/core/asa_norm.sv]
// Magnitudes of dot and cross, common bit length, and shift to a 40-bit pair (four stages).
module asa_norm (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  input  asa_pkg::tag_t                     in_tag,
  input  logic signed [asa_pkg::SumW-1:0]   dot,
  input  logic signed [asa_pkg::SumW-1:0]   cross_sum,
  output logic                              out_valid,
  output asa_pkg::tag_t                     out_tag,
  output logic [asa_pkg::NormBits-1:0]      x_init,
  output logic [asa_pkg::NormBits-1:0]      y_init
);
  import asa_pkg::*;

  function automatic logic [ClenW-1:0] chunk_len(input logic [ChunkW-1:0] c);
    logic [ClenW-1:0] n;
    n = '0;
    for (int j = 0; j < ChunkW; j++) begin
      if (c[j]) n = ClenW'(j + 1);
    end
    return n;
  endfunction

  logic                       v1, v2, v3, v4;
  tag_t                       tag1, tag2, tag3, tag4;
  logic [SumW-1:0]            ad1, ac1, ad2, ac2, ad3, ac3;
  logic [Chunks*ChunkW-1:0]   mix;
  logic [ClenW-1:0]           clen2 [Chunks];
  logic [LenW-1:0]            len_next, len3;
  logic [LenW-1:0]            shr, shl;
  logic [SumW-1:0]            xsh, ysh;
  logic [NormBits-1:0]        x_next, y_next, x4, y4;

  assign mix = (Chunks*ChunkW)'(ad1 | ac1);

  always_comb begin
    len_next = '0;
    for (int k = 0; k < Chunks; k++) begin
      if (clen2[k] != '0) len_next = LenW'(k * ChunkW) + LenW'(clen2[k]);
    end
  end

  always_comb begin
    shr    = '0;
    shl    = '0;
    xsh    = '0;
    ysh    = '0;
    if (len3 > LenW'(NormBits)) begin
      shr    = len3 - LenW'(NormBits);
      xsh    = ad3 >> shr;
      ysh    = ac3 >> shr;
      x_next = xsh[NormBits-1:0];
      y_next = ysh[NormBits-1:0];
    end else begin
      shl    = LenW'(NormBits) - len3;
      x_next = ad3[NormBits-1:0] << shl;
      y_next = ac3[NormBits-1:0] << shl;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end

    ad1 <= dot[SumW-1] ? SumW'(-dot) : SumW'(dot);
    ac1 <= cross_sum[SumW-1] ? SumW'(-cross_sum) : SumW'(cross_sum);
    tag1 <= tag_t'{
      degen: in_tag.degen,
      cw: in_tag.cw,
      dot_neg: dot[SumW-1],
      cross_nz: |cross_sum,
      cross_neg: cross_sum[SumW-1]
    };

    for (int k = 0; k < Chunks; k++) begin
      clen2[k] <= chunk_len(mix[k*ChunkW +: ChunkW]);
    end
    ad2  <= ad1;
    ac2  <= ac1;
    tag2 <= tag1;

    len3 <= len_next;
    ad3  <= ad2;
    ac3  <= ac2;
    tag3 <= tag2;

    x4   <= x_next;
    y4   <= y_next;
    tag4 <= tag3;
  end

  assign out_valid = v4;
  assign out_tag   = tag4;
  assign x_init    = x4;
  assign y_init    = y4;

endmodule

[rtl/core/asa_cordic.sv]
// Vectoring CORDIC, one register stage per micro-rotation, angle in 2^-32 turn.
module asa_cordic #(
  parameter int Stages = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  input  asa_pkg::tag_t                     in_tag,
  input  logic [asa_pkg::NormBits-1:0]      x_init,
  input  logic [asa_pkg::NormBits-1:0]      y_init,
  output logic                              out_valid,
  output asa_pkg::tag_t                     out_tag,
  output logic signed [asa_pkg::ZW-1:0]     z
);
  import asa_pkg::*;

  logic signed [XyW-1:0] x0, y0;
  logic signed [XyW-1:0] xr [Stages];
  logic signed [XyW-1:0] yr [Stages];
  logic signed [ZW-1:0]  zr [Stages];
  tag_t                  tr [Stages];
  logic signed [XyW-1:0] x_next [Stages];
  logic signed [XyW-1:0] y_next [Stages];
  logic signed [ZW-1:0]  z_next [Stages];
  logic [Stages-1:0]     vr;

  assign x0 = XyW'(x_init);
  assign y0 = XyW'(y_init);

  always_comb begin
    logic signed [XyW-1:0] xi, yi, dx, dy;
    logic signed [ZW-1:0]  zi, da;
    for (int i = 0; i < Stages; i++) begin
      if (i == 0) begin
        xi = x0;
        yi = y0;
        zi = '0;
      end else begin
        xi = xr[i-1];
        yi = yr[i-1];
        zi = zr[i-1];
      end
      dx = yi >>> i;
      dy = xi >>> i;
      da = ZW'(atan_turns(i));
      if (!yi[XyW-1]) begin
        x_next[i] = xi + dx;
        y_next[i] = yi - dy;
        z_next[i] = zi + da;
      end else begin
        x_next[i] = xi - dx;
        y_next[i] = yi + dy;
        z_next[i] = zi - da;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vr <= '0;
    end else begin
      vr <= {vr[Stages-2:0], in_valid};
    end
    for (int i = 0; i < Stages; i++) begin
      xr[i] <= x_next[i];
      yr[i] <= y_next[i];
      zr[i] <= z_next[i];
      if (i == 0) begin
        tr[i] <= in_tag;
      end else begin
        tr[i] <= tr[i-1];
      end
    end
  end

  assign out_valid = vr[Stages-1];
  assign out_tag   = tr[Stages-1];
  assign z         = zr[Stages-1];

endmodule

[rtl/core/asa_fin.sv]
// Clamp, quadrant and direction fold, and rounding to 1/65536 turn (four stages).
module asa_fin (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  input  asa_pkg::tag_t                     in_tag,
  input  logic signed [asa_pkg::ZW-1:0]     z,
  output logic                              done,
  output logic [asa_pkg::TurnW-1:0]         sweep_turns,
  output logic                              degenerate
);
  import asa_pkg::*;

  logic              v1, v2, v3, v4;
  tag_t              tag1, tag2, tag3;
  logic [ClampW-1:0] zc1;
  logic [AngW-1:0]   a2;
  logic [AdjW-1:0]   g3, r_next;
  logic [TurnW-1:0]  turns4;
  logic              degen4;

  assign r_next = g3 + RoundHalf;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end

    if (z[ZW-1]) begin
      zc1 <= '0;
    end else if (z > ZW'(QuarterTurn)) begin
      zc1 <= QuarterTurn;
    end else begin
      zc1 <= z[ClampW-1:0];
    end
    tag1 <= in_tag;

    a2   <= tag1.dot_neg ? HalfTurn - AngW'(zc1) : AngW'(zc1);
    tag2 <= tag1;

    g3   <= (tag2.cross_nz && (tag2.cross_neg == tag2.cw)) ?
            FullTurn - AdjW'(a2) : AdjW'(a2);
    tag3 <= tag2;

    turns4 <= tag3.degen ? '0 : r_next[TurnW +: TurnW];
    degen4 <= tag3.degen;
  end

  assign done        = v4;
  assign sweep_turns = turns4;
  assign degenerate  = degen4;

endmodule

[rtl/core/arc_sweep_angle.sv]
// Top level of the arc sweep angle pipeline.
//
//   channel  | handshake     | payload
//   ---------+---------------+-------------------------------------------------
//   arc in   | start / busy  | start_x start_y end_x end_y center_x center_y
//            |               | clockwise
//   sweep out| done          | sweep_turns degenerate
//
// One arc enters per cycle; busy is always low. Each arc passes in order
// through the product, normalization, CORDIC micro-rotation and folding and
// rounding stages. Results leave on done for one cycle and cannot be held
// off. Synchronous reset clears every valid bit.
module arc_sweep_angle #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [asa_pkg::CoordW-1:0] start_x,
  input  logic signed [asa_pkg::CoordW-1:0] start_y,
  input  logic signed [asa_pkg::CoordW-1:0] end_x,
  input  logic signed [asa_pkg::CoordW-1:0] end_y,
  input  logic signed [asa_pkg::CoordW-1:0] center_x,
  input  logic signed [asa_pkg::CoordW-1:0] center_y,
  input  logic                              clockwise,
  output logic                              done,
  output logic [asa_pkg::TurnW-1:0]         sweep_turns,
  output logic                              degenerate
);
  import asa_pkg::*;

  logic                   accept;
  logic                   pv, nv, cv;
  tag_t                   ptag, ntag, ctag;
  logic signed [SumW-1:0] dot, cross_sum;
  logic [NormBits-1:0]    x_init, y_init;
  logic signed [ZW-1:0]   z;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  asa_prod u_prod (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (accept),
    .start_x   (start_x),
    .start_y   (start_y),
    .end_x     (end_x),
    .end_y     (end_y),
    .center_x  (center_x),
    .center_y  (center_y),
    .clockwise (clockwise),
    .out_valid (pv),
    .out_tag   (ptag),
    .dot       (dot),
    .cross_sum (cross_sum)
  );

  asa_norm u_norm (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (pv),
    .in_tag    (ptag),
    .dot       (dot),
    .cross_sum (cross_sum),
    .out_valid (nv),
    .out_tag   (ntag),
    .x_init    (x_init),
    .y_init    (y_init)
  );

  asa_cordic #(
    .Stages (CORDIC_STAGES)
  ) u_cordic (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (nv),
    .in_tag    (ntag),
    .x_init    (x_init),
    .y_init    (y_init),
    .out_valid (cv),
    .out_tag   (ctag),
    .z         (z)
  );

  asa_fin u_fin (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (cv),
    .in_tag      (ctag),
    .z           (z),
    .done        (done),
    .sweep_turns (sweep_turns),
    .degenerate  (degenerate)
  );

endmodule

[bench/arc_sweep_checker.sv]
`timescale 1ns / 100ps
// Checker for the arc sweep angle block: predicts each sweep and compares the results.
module arc_sweep_checker #(
  parameter int STAGES = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic                              busy,
  input  logic signed [asa_pkg::CoordW-1:0] start_x,
  input  logic signed [asa_pkg::CoordW-1:0] start_y,
  input  logic signed [asa_pkg::CoordW-1:0] end_x,
  input  logic signed [asa_pkg::CoordW-1:0] end_y,
  input  logic signed [asa_pkg::CoordW-1:0] center_x,
  input  logic signed [asa_pkg::CoordW-1:0] center_y,
  input  logic                              clockwise,
  input  logic                              done,
  input  logic [asa_pkg::TurnW-1:0]         sweep_turns,
  input  logic                              degenerate,
  output int                                fail_count,
  output int                                in_flight
);

  localparam int NormLen = 40;
  localparam int LutLen  = 24;

  typedef struct packed {
    logic [asa_pkg::TurnW-1:0] turns;
    logic                      degen;
  } sweep_t;

  logic [31:0] atan_lut [0:LutLen-1] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
  };

  sweep_t pending_sweeps [$];
  sweep_t got;
  sweep_t want;
  int     mismatches = 0;

  function automatic sweep_t predict_sweep(
    input logic signed [31:0] px, py, qx, qy, ox, oy,
    input logic               cw
  );
    logic signed [32:0] sx, sy, ex, ey;
    logic signed [66:0] dot, cross_sum;
    logic [66:0]        mag_d, mag_c, norm_d, norm_c;
    int                 len, lc;
    longint             x, y, z, dx, dy;
    logic [63:0]        ang, rounded;
    sweep_t             r;
    sx = {px[31], px} - {ox[31], ox};
    sy = {py[31], py} - {oy[31], oy};
    ex = {qx[31], qx} - {ox[31], ox};
    ey = {qy[31], qy} - {oy[31], oy};
    if ((sx == 0 && sy == 0) || (ex == 0 && ey == 0)) begin
      r.turns = '0;
      r.degen = 1'b1;
      return r;
    end
    dot       = sx * ex + sy * ey;
    cross_sum = sx * ey - sy * ex;
    mag_d = dot[66] ? -dot : dot;
    mag_c = cross_sum[66] ? -cross_sum : cross_sum;
    len = 0;
    lc  = 0;
    for (int i = 0; i < 67; i++) begin
      if (mag_d[i]) len = i + 1;
      if (mag_c[i]) lc = i + 1;
    end
    if (lc > len) len = lc;
    if (len > NormLen) begin
      norm_d = mag_d >> (len - NormLen);
      norm_c = mag_c >> (len - NormLen);
    end else begin
      norm_d = mag_d << (NormLen - len);
      norm_c = mag_c << (NormLen - len);
    end
    x = {24'd0, norm_d[39:0]};
    y = {24'd0, norm_c[39:0]};
    z = 0;
    for (int i = 0; i < STAGES && i < LutLen; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x = x + dx;
        y = y - dy;
        z = z + longint'(atan_lut[i]);
      end else begin
        x = x - dx;
        y = y + dy;
        z = z - longint'(atan_lut[i]);
      end
    end
    if (z < 0) z = 0;
    if (z > (longint'(1) << 30)) z = longint'(1) << 30;
    ang = 64'(z);
    if (dot < 0) ang = 64'h8000_0000 - ang;
    if (cross_sum != 0 && ((cross_sum < 0) == cw)) ang = 64'h1_0000_0000 - ang;
    rounded = ang + 64'h8000;
    r.turns = rounded[31:16];
    r.degen = 1'b0;
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst) begin
      if (done) begin
        got.turns = sweep_turns;
        got.degen = degenerate;
        if (pending_sweeps.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected sweep beat: turns %0d degenerate %0d",
                     got.turns, got.degen);
          mismatches++;
        end else begin
          want = pending_sweeps.pop_front();
          if (got.turns !== want.turns || got.degen !== want.degen) begin
            if (mismatches < 10)
              $display("sweep mismatch: exp turns %0d degen %0d, got turns %0d degen %0d",
                       want.turns, want.degen, got.turns, got.degen);
            mismatches++;
          end
        end
      end
      if (start && !busy)
        pending_sweeps.insert(pending_sweeps.size(),
                              predict_sweep(start_x, start_y, end_x, end_y,
                                            center_x, center_y, clockwise));
    end
    fail_count <= mismatches;
    in_flight  <= pending_sweeps.size();
  end

endmodule

[bench/arc_sweep_angle_tb.sv]
`timescale 1ns / 100ps
// Top of the arc sweep angle testbench: clock, reset, arc stimulus and verdict.
module arc_sweep_angle_tb;

  localparam int Stages     = 16;
  localparam int Latency    = 13 + Stages;
  localparam int CycleLimit = 400_000;
  localparam int RandomArcs = 1000;
  localparam int CalmTail   = 150;

  logic                              clk       = 1'b0;
  logic                              rst       = 1'b1;
  logic                              start     = 1'b0;
  logic signed [asa_pkg::CoordW-1:0] start_x   = '0;
  logic signed [asa_pkg::CoordW-1:0] start_y   = '0;
  logic signed [asa_pkg::CoordW-1:0] end_x     = '0;
  logic signed [asa_pkg::CoordW-1:0] end_y     = '0;
  logic signed [asa_pkg::CoordW-1:0] center_x  = '0;
  logic signed [asa_pkg::CoordW-1:0] center_y  = '0;
  logic                              clockwise = 1'b0;
  logic                              busy;
  logic                              done;
  logic [asa_pkg::TurnW-1:0]         sweep_turns;
  logic                              degenerate;
  int                                fail_count;
  int                                in_flight;
  int                                cycle_count = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  arc_sweep_angle #(
    .CORDIC_STAGES(Stages)
  ) i_dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .start_x    (start_x),
    .start_y    (start_y),
    .end_x      (end_x),
    .end_y      (end_y),
    .center_x   (center_x),
    .center_y   (center_y),
    .clockwise  (clockwise),
    .done       (done),
    .sweep_turns(sweep_turns),
    .degenerate (degenerate)
  );

  arc_sweep_checker #(
    .STAGES(Stages)
  ) i_checker (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .start_x    (start_x),
    .start_y    (start_y),
    .end_x      (end_x),
    .end_y      (end_y),
    .center_x   (center_x),
    .center_y   (center_y),
    .clockwise  (clockwise),
    .done       (done),
    .sweep_turns(sweep_turns),
    .degenerate (degenerate),
    .fail_count (fail_count),
    .in_flight  (in_flight)
  );

  task automatic send_arc(input logic [31:0] sx, sy, ex, ey, cx, cy, input logic cw);
    start_x   <= sx;
    start_y   <= sy;
    end_x     <= ex;
    end_y     <= ey;
    center_x  <= cx;
    center_y  <= cy;
    clockwise <= cw;
    start     <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic hold_arcs(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic drain_sweeps();
    start <= 1'b0;
    @(posedge clk);
    while (in_flight != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] near_offset(input int k);
    return $urandom_range(0, 2 ** (k + 1)) - 2 ** k;
  endfunction

  function automatic logic [31:0] edge_coord();
    case ($urandom_range(0, 3))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'h0000_0000;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_random_arc();
    logic [31:0] cx, cy, ox, oy, sx, sy, ex, ey;
    logic        cw;
    int          k;
    int          m;
    cw = 1'($urandom_range(0, 1));
    cx = $urandom;
    cy = $urandom;
    k  = $urandom_range(0, 20);
    ox = near_offset(k);
    oy = near_offset(k);
    sx = cx + ox;
    sy = cy + oy;
    ex = cx + near_offset(k);
    ey = cy + near_offset(k);
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        sx = $urandom;
        sy = $urandom;
        ex = $urandom;
        ey = $urandom;
      end
      5: begin
        if ($urandom_range(0, 1)) begin
          sx = cx;
          sy = cy;
        end else begin
          ex = cx;
          ey = cy;
        end
      end
      6: begin
        m  = int'($urandom_range(0, 6)) - 3;
        ex = cx + m * ox;
        ey = cy + m * oy;
      end
      7: begin
        ex = sx + near_offset($urandom_range(0, 2));
        ey = sy + near_offset($urandom_range(0, 2));
      end
      8: begin
        cx = edge_coord();
        cy = edge_coord();
        sx = edge_coord();
        sy = edge_coord();
        ex = edge_coord();
        ey = edge_coord();
      end
      9: begin
        ex = cx - ox + near_offset($urandom_range(0, 2));
        ey = cy - oy + near_offset($urandom_range(0, 2));
      end
      default: ;
    endcase
    send_arc(sx, sy, ex, ey, cx, cy, cw);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    send_arc(0, 0, 0, 0, 0, 0, 1'b0);
    send_arc(100, 200, 300, 400, 100, 200, 1'b1);
    send_arc(-5, 7, 9, 9, 9, 9, 1'b0);
    send_arc(65536, 0, 0, 65536, 0, 0, 1'b0);
    send_arc(65536, 0, 0, 65536, 0, 0, 1'b1);
    send_arc(0, 65536, 65536, 0, 0, 0, 1'b0);
    send_arc(1, 0, -1, 0, 0, 0, 1'b0);
    send_arc(1, 0, -1, 0, 0, 0, 1'b1);
    send_arc(5, 7, 5, 7, 0, 0, 1'b1);
    send_arc(32'h4000_0000, 0, 32'h4000_0000, 1, 0, 0, 1'b0);
    send_arc(32'h4000_0000, 0, 32'h4000_0000, 1, 0, 0, 1'b1);
    send_arc(32'h4000_0000, 0, 32'h4000_0000, -1, 0, 0, 1'b1);
    send_arc(1, 0, 0, 1, 0, 0, 1'b1);
    send_arc(-3, 1, 2, -5, 0, 0, 1'b0);
    send_arc(-3, 1, 2, -5, 0, 0, 1'b1);
    send_arc(32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
             32'h8000_0000, 32'h8000_0000, 1'b0);
    send_arc(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
             32'h7fff_ffff, 32'h7fff_ffff, 1'b1);
    send_arc(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff,
             0, 0, 1'b1);
    send_arc(32'hffff_ffff, 32'hffff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
             32'h8000_0000, 32'h8000_0000, 1'b0);
    send_arc(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_fffe, 32'h8000_0000,
             32'h8000_0000, 32'h7fff_ffff, 1'b1);
    send_arc(-65536, -65536, 65536, -65536, 0, 0, 1'b0);
    drain_sweeps();

    for (int n = 0; n < RandomArcs; n++) begin
      if (n == RandomArcs / 2) drain_sweeps();
      if (n < RandomArcs - CalmTail && $urandom_range(0, 7) == 0)
        hold_arcs($urandom_range(1, 16));
      send_random_arc();
    end

    drain_sweeps();
    repeat (Latency + 8) @(posedge clk);
    if (fail_count == 0 && in_flight == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
